>>> rtl/cvr_pkg.sv
// Shared constants and types for the collinear vertex removal block.
package cvr_pkg;

	// Configuration port geometry: three registers, read as 32-bit words, at byte addresses 0, 4, 8
	localparam int ADDR_W = 4;

	typedef logic [ADDR_W-3:0] reg_idx_t;

	localparam reg_idx_t REG_COS = 2'd0;
	localparam reg_idx_t REG_SIN = 2'd1;
	localparam reg_idx_t REG_ARC = 2'd2;

	// Register reset values
	localparam logic [15:0] COS_RST = 16'h7FFF;
	localparam logic [14:0] SIN_RST = 15'h0000;
	localparam logic [30:0] ARC_RST = 31'h0000_0001;

endpackage

>>> rtl/collinear_vertex_removal.sv
// Top level: streaming removal of collinear polyline vertices on a shared multiplier.
//
//  channel   direction  handshake                 payload
//  vtx       in         vtx_valid / vtx_stall     pos_x pos_y pos_z bulge seg_width last_vertex
//  res       out        res_valid / res_stall     out_x out_y out_z out_bulge out_width out_last
//  apb       in/out     psel penable pwrite pready paddr pwdata prdata
//
// After a vertex is accepted, the next one waits until the sequencer is idle again, and longer
// while the result side stalls. The longest case is the angle test: nine steps through the one
// shared signed multiplier and its accumulators, then a decision and up to two results.
// vtx_stall is high whenever the sequencer is not idle; the result register lets a new
// vertex be taken while the previous result still waits on res_stall.
// arst_n clears the sequencer, the polyline state and the configuration registers.
module collinear_vertex_removal #(
	parameter int COORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      vtx_valid,
	output logic                      vtx_stall,
	input  logic signed [31:0]        pos_x,
	input  logic signed [31:0]        pos_y,
	input  logic signed [31:0]        pos_z,
	input  logic signed [31:0]        bulge,
	input  logic signed [31:0]        seg_width,
	input  logic                      last_vertex,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic signed [31:0]        out_x,
	output logic signed [31:0]        out_y,
	output logic signed [31:0]        out_z,
	output logic signed [31:0]        out_bulge,
	output logic signed [31:0]        out_width,
	output logic                      out_last,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cvr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import cvr_pkg::*;

	// Coordinate width used by the test, and derived datapath widths
	localparam int CW  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int DW  = CW + 1;          // coordinate difference
	localparam int S   = CW + 2;          // chunk split point for the wide operands
	localparam int MW  = CW + 3;          // multiplier operand
	localparam int PW  = 2 * MW;          // multiplier product
	localparam int CRW = 2 * CW + 2;      // cross and dot accumulators
	localparam int CHW = CRW - S;         // upper chunk of cross or dot
	localparam int TW  = 2 * CW + 18;     // tolerance test accumulator

	// Multiplier step codes
	localparam logic [3:0] MUL_AX_BY = 4'd0;
	localparam logic [3:0] MUL_AY_BX = 4'd1;
	localparam logic [3:0] MUL_AX_BX = 4'd2;
	localparam logic [3:0] MUL_AY_BY = 4'd3;
	localparam logic [3:0] MUL_CT_CL = 4'd4;
	localparam logic [3:0] MUL_CT_CH = 4'd5;
	localparam logic [3:0] MUL_ST_DL = 4'd6;
	localparam logic [3:0] MUL_ST_DH = 4'd7;
	localparam logic [3:0] MUL_DRAIN = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DECIDE,
		ST_EMIT_PEND,
		ST_FIN,
		ST_EMIT_CUR
	} state_t;

	function automatic logic signed [DW-1:0] coord(input logic [31:0] v);
		return $signed({v[CW-1], v[CW-1:0]});
	endfunction

	// Configuration registers
	logic signed [15:0] cos_q;
	logic [14:0]        sin_q;
	logic [30:0]        arc_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	// Sequencer and polyline state
	state_t      state_q;
	logic [3:0]  step_q;
	logic        started_q;
	logic        pending_q;
	logic [31:0] kept_x_q;
	logic [31:0] kept_y_q;
	logic        ovalid_q;

	// Current vertex and held vertex
	logic [31:0] cur_x_q, cur_y_q, cur_z_q, cur_b_q, cur_w_q;
	logic        cur_last_q;
	logic [31:0] pend_x_q, pend_y_q, pend_z_q, pend_b_q, pend_w_q;

	// Shared multiplier datapath
	logic signed [DW-1:0]  ax_q, ay_q, bx_q, by_q;
	logic signed [MW-1:0]  op_a, op_b;
	logic signed [PW-1:0]  prod_s1;
	logic signed [CRW-1:0] cross_q, dot_q;
	logic signed [TW-1:0]  t_q;
	logic [CRW-1:0]        cmag;
	logic signed [TW-1:0]  prod_t, prod_sh;
	logic [CRW-1:0]        prod_c;

	logic        vtx_acc;
	logic        out_free;
	logic        emit;
	logic [32:0] bmag;
	logic        arc_hit;
	logic        keep;

	assign vtx_stall = (state_q != ST_IDLE);
	assign vtx_acc   = vtx_valid && !vtx_stall;
	assign out_free  = !ovalid_q || !res_stall;
	assign emit      = ((state_q == ST_EMIT_PEND) || (state_q == ST_EMIT_CUR)) && out_free;
	assign res_valid = ovalid_q;
	assign pready    = 1'b1;

	// APB register file
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RST;
			sin_q <= SIN_RST;
			arc_q <= ARC_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_COS: cos_q <= pwdata[15:0];
				REG_SIN: sin_q <= pwdata[14:0];
				REG_ARC: arc_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_COS: prdata = {16'h0000, cos_q};
			REG_SIN: prdata = {17'h00000, sin_q};
			REG_ARC: prdata = {1'b0, arc_q};
			default: prdata = 32'h0000_0000;
		endcase
	end

	// Arc test on the held vertex
	assign bmag    = pend_b_q[31] ? (33'd0 - {1'b1, pend_b_q}) : {1'b0, pend_b_q};
	assign arc_hit = bmag > {2'b00, arc_q};

	// Angle decision; a zero cross product is decided by the reversal rule alone
	assign keep = (cross_q == '0) ? (dot_q[CRW-1] && !cos_q[15])
	                              : (!t_q[TW-1] && (t_q != '0));

	// Multiplier operand selection
	assign cmag = cross_q[CRW-1] ? (CRW'(0) - cross_q) : cross_q;

	always_comb begin
		case (step_q)
			MUL_AX_BY: begin
				op_a = {{2{ax_q[DW-1]}}, ax_q};
				op_b = {{2{by_q[DW-1]}}, by_q};
			end
			MUL_AY_BX: begin
				op_a = {{2{ay_q[DW-1]}}, ay_q};
				op_b = {{2{bx_q[DW-1]}}, bx_q};
			end
			MUL_AX_BX: begin
				op_a = {{2{ax_q[DW-1]}}, ax_q};
				op_b = {{2{bx_q[DW-1]}}, bx_q};
			end
			MUL_AY_BY: begin
				op_a = {{2{ay_q[DW-1]}}, ay_q};
				op_b = {{2{by_q[DW-1]}}, by_q};
			end
			MUL_CT_CL: begin
				op_a = {{(MW-16){cos_q[15]}}, cos_q};
				op_b = {1'b0, cmag[S-1:0]};
			end
			MUL_CT_CH: begin
				op_a = {{(MW-16){cos_q[15]}}, cos_q};
				op_b = {{(MW-CHW){1'b0}}, cmag[CRW-1:S]};
			end
			MUL_ST_DL: begin
				op_a = {{(MW-15){1'b0}}, sin_q};
				op_b = {1'b0, dot_q[S-1:0]};
			end
			MUL_ST_DH: begin
				op_a = {{(MW-15){1'b0}}, sin_q};
				op_b = {{(MW-CHW){dot_q[CRW-1]}}, dot_q[CRW-1:S]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod_t  = {{(TW-PW){prod_s1[PW-1]}}, prod_s1};
	assign prod_sh = prod_t <<< S;
	assign prod_c  = prod_s1[CRW-1:0];

	// Datapath registers: vertex capture, held vertex, differences, multiplier and accumulators
	always_ff @(posedge clk) begin
		if (vtx_acc) begin
			cur_x_q    <= pos_x;
			cur_y_q    <= pos_y;
			cur_z_q    <= pos_z;
			cur_b_q    <= bulge;
			cur_w_q    <= seg_width;
			cur_last_q <= last_vertex;
			ax_q       <= coord(pend_x_q) - coord(kept_x_q);
			ay_q       <= coord(pend_y_q) - coord(kept_y_q);
			bx_q       <= coord(pos_x) - coord(pend_x_q);
			by_q       <= coord(pos_y) - coord(pend_y_q);
		end

		if (state_q == ST_FIN && !cur_last_q) begin
			pend_x_q <= cur_x_q;
			pend_y_q <= cur_y_q;
			pend_z_q <= cur_z_q;
			pend_b_q <= cur_b_q;
			pend_w_q <= cur_w_q;
		end

		if (state_q == ST_MUL) begin
			prod_s1 <= op_a * op_b;
			// accumulate the product issued on the previous step
			case (step_q)
				MUL_AY_BX: cross_q <= prod_c;
				MUL_AX_BX: cross_q <= cross_q - prod_c;
				MUL_AY_BY: dot_q   <= prod_c;
				MUL_CT_CL: dot_q   <= dot_q + prod_c;
				MUL_CT_CH: t_q     <= prod_t;
				MUL_ST_DL: t_q     <= t_q + prod_sh;
				MUL_ST_DH: t_q     <= t_q - prod_t;
				MUL_DRAIN: t_q     <= t_q - prod_sh;
				default: ;
			endcase
		end
	end

	// Sequencer, polyline state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			started_q <= 1'b0;
			pending_q <= 1'b0;
			kept_x_q  <= '0;
			kept_y_q  <= '0;
			ovalid_q  <= 1'b0;
			out_x     <= '0;
			out_y     <= '0;
			out_z     <= '0;
			out_bulge <= '0;
			out_width <= '0;
			out_last  <= 1'b0;
		end else begin
			// result register: loaded on an emit, freed when its transaction completes
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && !res_stall) begin
				ovalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (vtx_acc) begin
						step_q <= MUL_AX_BY;
						if (!started_q) begin
							state_q <= ST_EMIT_CUR;
						end else if (pending_q) begin
							state_q <= arc_hit ? ST_EMIT_PEND : ST_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == MUL_DRAIN) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= keep ? ST_EMIT_PEND : ST_FIN;
				end
				ST_EMIT_PEND: begin
					if (out_free) begin
						out_x     <= pend_x_q;
						out_y     <= pend_y_q;
						out_z     <= pend_z_q;
						out_bulge <= pend_b_q;
						out_width <= pend_w_q;
						out_last  <= 1'b0;
						kept_x_q  <= pend_x_q;
						kept_y_q  <= pend_y_q;
						state_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					pending_q <= !cur_last_q;
					state_q   <= cur_last_q ? ST_EMIT_CUR : ST_IDLE;
				end
				ST_EMIT_CUR: begin
					if (out_free) begin
						out_x     <= cur_x_q;
						out_y     <= cur_y_q;
						out_z     <= cur_z_q;
						out_bulge <= cur_b_q;
						out_width <= cur_w_q;
						out_last  <= cur_last_q;
						// first vertex opens a polyline, a last vertex closes it
						started_q <= !cur_last_q;
						pending_q <= 1'b0;
						if (!cur_last_q) begin
							kept_x_q <= cur_x_q;
							kept_y_q <= cur_y_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/cvr_checker.sv
// Port-level checker for the collinear vertex removal block, with its bind.
module cvr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               vtx_valid,
	input logic               vtx_stall,
	input logic               res_valid,
	input logic               res_stall,
	input logic signed [31:0] out_x,
	input logic               out_last,
	input logic               pready
);

	// A stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its x coordinate and last flag
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(out_x) && $stable(out_last))
		else $error("result payload changed while stalled");

	// The block is busy in the cycle after taking a vertex
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_stall |=> vtx_stall)
		else $error("vertex taken without a busy cycle");

	// The configuration port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind collinear_vertex_removal cvr_checker u_cvr_checker (.*);
